### hdl/tos_pkg.sv
// Package for the timestamp opcode scanner: opcode bytes, context rule
// constants, result word type and the follower byte table.
// No dependencies.
package tos_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam int WinDepth   = 10;
  localparam int FifoDepth  = 4;

  // Address results wrap at ADDR_WIDTH and are then cut to 32 bits.
  localparam logic [31:0] PatchAddrMask =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [7:0] OpFirst    = 8'h0F;
  localparam logic [7:0] OpSecond   = 8'h31;
  localparam logic [7:0] PatchFirst = 8'hEF;
  localparam logic [7:0] PatchSecond = 8'h90;

  localparam logic [7:0] FolMovLoad = 8'h8B;
  localparam logic [7:0] FolMovStore = 8'h89;
  localparam logic [7:0] FolPush    = 8'h50;
  localparam logic [7:0] FolAdd     = 8'h01;
  localparam logic [7:0] FolGrp3    = 8'hF7;

  localparam logic [7:0] CtxMovByte = 8'h88;
  localparam logic [7:0] CtxSib5c   = 8'h5C;
  localparam logic [7:0] CtxSib24   = 8'h24;
  localparam logic [7:0] CtxModrm0c = 8'h0C;
  localparam logic [7:0] CtxImm04   = 8'h04;
  localparam logic [7:0] CtxGrp1    = 8'h83;
  localparam logic [7:0] CtxModrmE2 = 8'hE2;
  localparam logic [7:0] CtxCall    = 8'hE8;
  localparam logic [7:0] CtxZero    = 8'h00;
  localparam logic [7:0] CtxOnes    = 8'hFF;

  typedef logic [WinDepth-1:0][7:0] win_bytes_t;
  typedef logic [WinDepth-1:0]      win_valid_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        last;
  } result_t;

  // Third bytes that may follow the timestamp opcode.
  function automatic logic is_follower(input logic [7:0] b);
    logic hit;
    case (b)
      8'h89, 8'hC3, 8'h8B, 8'hB9, 8'hC7, 8'h8D, 8'h68, 8'h5A, 8'h29, 8'hF3,
      8'hE9, 8'h2B, 8'h50, 8'h0F, 8'h3B, 8'hD9, 8'h57, 8'h85, 8'h83, 8'h33,
      8'hF7, 8'h8A, 8'h56, 8'h6A, 8'h39, 8'hEB, 8'hF6, 8'hA1, 8'h01,
      8'hA3: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### hdl/timestamp_opcode_scanner.sv
// Timestamp opcode scanner: ten-byte sliding window, context rules and a
// four-word result queue. Depends on tos_pkg.
//
// Usage: code bytes enter on the input channel (in_valid / in_stall, fields
// data_byte and end_of_section), one word per byte, in section order.
// end_of_section marks the final byte; the window and the byte offset then
// clear so the next word starts a new section. base_addr is loaded through
// cfg_wr_en / cfg_wr_data while the block is idle.
// Results leave on the output channel (out_valid / out_stall) as patch_addr,
// the address of a confirmed 0F byte, with last_in_run on the final result
// of one input word. A candidate is decided when the byte four past its 0F
// arrives, or at end of section.
// Throughput: one input word per cycle while in_stall is low. A result is
// registered into the queue as the word that decides it is accepted. An
// end-of-section word can produce two results, which leave one at a time.
// in_stall rises once three or more results are queued (fewer than two free
// entries), so a stalled receiver backs up the input after three or four
// queued results.
// Reset (rst, synchronous) clears the window, the offset, base_addr and the
// queue.
module timestamp_opcode_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_section,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] patch_addr,
  output logic        last_in_run
);
  import tos_pkg::*;

  localparam int PtrBits = $clog2(FifoDepth);

  win_bytes_t  win_bytes;
  win_valid_t  win_valid;
  logic [31:0] byte_offset;
  logic [31:0] section_addr;

  result_t               fifo_mem [FifoDepth];
  logic [PtrBits-1:0]    wr_ptr;
  logic [PtrBits-1:0]    rd_ptr;
  logic [PtrBits:0]      fifo_count;

  win_bytes_t  wb;
  win_bytes_t  wb5;
  win_bytes_t  wb6;
  win_valid_t  wv;
  logic        conf5;
  logic        conf6;
  logic        conf7;
  logic [31:0] addr5;
  logic [31:0] addr6;
  logic [31:0] addr7;
  logic        in_take;
  logic        out_take;
  logic [1:0]  push_n;
  result_t     res0;
  result_t     res1;

  function automatic logic is_byte(input win_bytes_t b, input win_valid_t v,
                                   input int idx, input logic [7:0] val);
    logic hit;
    hit = 1'b0;
    if (idx >= 0 && idx < WinDepth) begin
      hit = v[idx] && (b[idx] == val);
    end
    return hit;
  endfunction

  // Decides the candidate whose 0F byte sits at window index c.
  function automatic logic confirm_at(input win_bytes_t b, input win_valid_t v,
                                      input int c);
    logic       ok;
    logic [7:0] f;
    f  = b[c+2];
    ok = is_byte(b, v, c, OpFirst) && is_byte(b, v, c + 1, OpSecond) &&
         v[c+2] && is_follower(f);
    if (f == FolMovLoad) begin
      if (is_byte(b, v, c - 2, CtxMovByte) && is_byte(b, v, c - 1, CtxSib5c)) begin
        ok = 1'b0;
      end
      if (is_byte(b, v, c - 2, CtxSib24) && is_byte(b, v, c - 1, CtxModrm0c)) begin
        ok = 1'b0;
      end
    end
    if (f == FolMovStore && is_byte(b, v, c + 4, FolMovLoad) &&
        is_byte(b, v, c - 5, CtxImm04)) begin
      ok = 1'b0;
    end
    if (f == FolPush && is_byte(b, v, c - 2, CtxGrp1) &&
        is_byte(b, v, c - 1, CtxModrmE2)) begin
      ok = 1'b0;
    end
    if (f == FolAdd && is_byte(b, v, c - 1, CtxCall) &&
        is_byte(b, v, c + 3, CtxZero)) begin
      ok = 1'b0;
    end
    if (f == FolGrp3 && is_byte(b, v, c - 1, CtxCall) &&
        is_byte(b, v, c + 3, CtxOnes)) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  assign in_stall  = (fifo_count > (PtrBits+1)'(FifoDepth - 2));
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (fifo_count != '0);
  assign out_take  = out_valid && !out_stall;
  assign patch_addr  = fifo_mem[rd_ptr].addr;
  assign last_in_run = fifo_mem[rd_ptr].last;

  // Window after the new byte shifts in; confirmed pairs are overwritten in
  // place so that the later candidates see the patched bytes.
  always_comb begin
    wb = {data_byte, win_bytes[WinDepth-1:1]};
    wv = {1'b1, win_valid[WinDepth-1:1]};

    conf5 = confirm_at(wb, wv, 5);
    wb5 = wb;
    if (conf5) begin
      wb5[5] = PatchFirst;
      wb5[6] = PatchSecond;
    end

    conf6 = end_of_section && confirm_at(wb5, wv, 6);
    wb6 = wb5;
    if (conf6) begin
      wb6[6] = PatchFirst;
      wb6[7] = PatchSecond;
    end

    conf7 = end_of_section && confirm_at(wb6, wv, 7);

    addr5 = (section_addr - 32'd4) & PatchAddrMask;
    addr6 = (section_addr - 32'd3) & PatchAddrMask;
    addr7 = (section_addr - 32'd2) & PatchAddrMask;

    push_n = 2'({1'b0, conf5} + {1'b0, conf6} + {1'b0, conf7});

    res0.addr = conf5 ? addr5 : (conf6 ? addr6 : addr7);
    res0.last = (push_n == 2'd1);
    res1.addr = conf7 ? addr7 : addr6;
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_bytes    <= '0;
      win_valid    <= '0;
      byte_offset  <= '0;
      section_addr <= '0;
    end else if (cfg_wr_en) begin
      section_addr <= cfg_wr_data + byte_offset;
    end else if (in_take) begin
      if (end_of_section) begin
        win_bytes    <= '0;
        win_valid    <= '0;
        byte_offset  <= '0;
        section_addr <= section_addr - byte_offset;
      end else begin
        win_bytes    <= wb5;
        win_valid    <= wv;
        byte_offset  <= byte_offset + 32'd1;
        section_addr <= section_addr + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (in_take) begin
        wr_ptr <= wr_ptr + PtrBits'(push_n);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      fifo_count <= fifo_count + (in_take ? (PtrBits+1)'(push_n) : '0)
                    - (out_take ? (PtrBits+1)'(1) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
      if (push_n == 2'd2) begin
        fifo_mem[wr_ptr + PtrBits'(1)] <= res1;
      end
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= (PtrBits+1)'(FifoDepth))
    else $error("result queue over capacity");

  a_section_clear: assert property (@(posedge clk) disable iff (rst)
    (in_take && end_of_section) |=> (win_valid == '0 && byte_offset == '0))
    else $error("window not cleared after end of section");

  a_valid_contig: assert property (@(posedge clk) disable iff (rst)
    ((~win_valid) & ((~win_valid) + WinDepth'(1))) == '0)
    else $error("window valid bits not contiguous from newest byte");

  a_two_at_end: assert property (@(posedge clk) disable iff (rst)
    (in_take && push_n == 2'd2) |-> end_of_section)
    else $error("two results from a word that is not end of section");

endmodule

### verif/timestamp_opcode_scanner_test.sv
`timescale 1ns / 1ps
// Self-checking bench for timestamp_opcode_scanner: feeds code sections byte by
// byte, predicts the confirmed patch addresses and checks every result word.
// Depends on tos_pkg and the scanner RTL.
module timestamp_opcode_scanner_test;
  import tos_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseBytes    = 270;

  localparam logic [29:0][7:0] FollowerBytes = {
    8'h89, 8'hC3, 8'h8B, 8'hB9, 8'hC7, 8'h8D, 8'h68, 8'h5A, 8'h29, 8'hF3,
    8'hE9, 8'h2B, 8'h50, 8'h0F, 8'h3B, 8'hD9, 8'h57, 8'h85, 8'h83, 8'h33,
    8'hF7, 8'h8A, 8'h56, 8'h6A, 8'h39, 8'hEB, 8'hF6, 8'hA1, 8'h01, 8'hA3
  };

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } code_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        end_of_section = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] patch_addr;
  logic        last_in_run;

  code_word_t pending_words[$];
  result_t    expected_patches[$];

  // Shadow of the scanner: byte window (index 9 newest), offset, base address.
  logic [7:0]  win_b [WinDepth];
  logic        win_v [WinDepth];
  logic [31:0] sect_offset;
  logic [31:0] sect_base;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  int sections_sent = 0;
  int patches_checked = 0;
  int double_hits = 0;
  int base_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  timestamp_opcode_scanner u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_section (end_of_section),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .patch_addr     (patch_addr),
    .last_in_run    (last_in_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic in_follower_list(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 30; i++) begin
      if (FollowerBytes[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // A window slot outside the section never matches any value.
  function automatic logic byte_is(input int idx, input logic [7:0] v);
    if (idx < 0 || idx >= WinDepth) return 1'b0;
    return win_v[idx] && (win_b[idx] == v);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < WinDepth; i++) begin
      win_b[i] = '0;
      win_v[i] = 1'b0;
    end
    sect_offset = '0;
  endtask

  task automatic predict_patches(input logic [7:0] b, input logic eos);
    result_t    found [2];
    int         n;
    int         top;
    logic       hit;
    logic [7:0] fol;
    n = 0;
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_b[i] = win_b[i+1];
      win_v[i] = win_v[i+1];
    end
    win_b[WinDepth-1] = b;
    win_v[WinDepth-1] = 1'b1;
    // Normally only the candidate four bytes back is decided; the last byte
    // of a section also flushes the two younger ones.
    top = eos ? 7 : 5;
    for (int c = 5; c <= top; c++) begin
      hit = n < 2 && byte_is(c, OpFirst) && byte_is(c + 1, OpSecond) && win_v[c+2] &&
            in_follower_list(win_b[c+2]);
      fol = win_b[c+2];
      if (hit && fol == FolMovLoad &&
          ((byte_is(c - 2, CtxMovByte) && byte_is(c - 1, CtxSib5c)) ||
           (byte_is(c - 2, CtxSib24) && byte_is(c - 1, CtxModrm0c))))
        hit = 1'b0;
      if (hit && fol == FolMovStore && byte_is(c + 4, FolMovLoad) && byte_is(c - 5, CtxImm04))
        hit = 1'b0;
      if (hit && fol == FolPush && byte_is(c - 2, CtxGrp1) && byte_is(c - 1, CtxModrmE2))
        hit = 1'b0;
      if (hit && fol == FolAdd && byte_is(c - 1, CtxCall) && byte_is(c + 3, CtxZero))
        hit = 1'b0;
      if (hit && fol == FolGrp3 && byte_is(c - 1, CtxCall) && byte_is(c + 3, CtxOnes))
        hit = 1'b0;
      if (hit) begin
        found[n].addr = (sect_base + (sect_offset - 32'(WinDepth - 1 - c))) & PatchAddrMask;
        found[n].last = 1'b0;
        // Later context checks see the patched bytes.
        win_b[c]   = PatchFirst;
        win_b[c+1] = PatchSecond;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      expected_patches.insert(expected_patches.size(), found[i]);
    end
    if (n == 2) double_hits++;
    if (eos) clear_window();
    else sect_offset = sect_offset + 32'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : word_driver
    code_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_patches(data_byte, end_of_section);
        words_sent++;
        if (end_of_section) sections_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid       <= 1'b1;
          data_byte      <= w.data;
          end_of_section <= w.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_patches.size() == 0) begin
          report_mismatch("result word with none expected", patch_addr, '0);
        end else begin
          want = expected_patches.pop_front();
          patches_checked++;
          if (patch_addr !== want.addr) report_mismatch("patch_addr", patch_addr, want.addr);
          if (last_in_run !== want.last)
            report_mismatch("last_in_run", 32'(last_in_run), 32'(want.last));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WatchdogLimit, expected_patches.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic eos);
    code_word_t w;
    w.data = b;
    w.eos  = eos;
    pending_words.insert(pending_words.size(), w);
  endtask

  // Queues a whole section given as right-justified packed bytes, first byte
  // in the most significant position.
  task automatic queue_run(input logic [8*16-1:0] bytes, input int n);
    for (int i = n - 1; i >= 0; i--) push_word(bytes[8*i +: 8], i == 0);
  endtask

  // Random section: mostly opcode patterns with and without their rejecting
  // context, some of them broken by one random byte, mixed with plain noise.
  task automatic queue_section(input int len);
    logic [7:0]    sect_q [$];
    logic [8*10-1:0] pat;
    int            plen;
    while (sect_q.size() < len) begin
      pat = '0;
      case ($urandom_range(9))
        0, 1: begin
          pat = 80'($urandom_range(255));
          plen = 1;
        end
        2: begin
          pat = 80'({OpFirst, OpSecond});
          plen = 2;
        end
        3: begin
          pat = 80'({($urandom_range(1) ? {CtxMovByte, CtxSib5c} : {CtxSib24, CtxModrm0c}),
                     OpFirst, OpSecond, FolMovLoad});
          plen = 5;
        end
        4: begin
          pat = {CtxImm04, 32'($urandom), OpFirst, OpSecond, FolMovStore,
                 8'($urandom_range(255)), FolMovLoad};
          plen = 10;
        end
        5: begin
          pat = 80'({CtxGrp1, CtxModrmE2, OpFirst, OpSecond, FolPush});
          plen = 5;
        end
        6: begin
          pat = 80'({CtxCall, OpFirst, OpSecond, FolAdd, CtxZero});
          plen = 5;
        end
        7: begin
          pat = 80'({CtxCall, OpFirst, OpSecond, FolGrp3, CtxOnes});
          plen = 5;
        end
        default: begin
          pat = 80'({OpFirst, OpSecond, FollowerBytes[$urandom_range(29)]});
          plen = 3;
        end
      endcase
      if (plen > 1 && $urandom_range(4) == 0)
        pat[8*$urandom_range(plen - 1) +: 8] = 8'($urandom_range(255));
      for (int i = plen - 1; i >= 0; i--) sect_q.insert(sect_q.size(), pat[8*i +: 8]);
    end
    // Cutting the section short leaves candidates for the end-of-section flush.
    while (sect_q.size() > len) void'(sect_q.pop_back());
    for (int i = 0; i < len; i++) push_word(sect_q[i], i == len - 1);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_patches.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    // The last word may have caused no result; give the block time to settle.
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sect_base = v;
    base_writes++;
  endtask

  initial begin
    int          queued;
    int          len;
    int          sel;
    logic        paused;
    logic [31:0] next_base;
    clear_window();
    sect_base = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed sections at the reset base: too short to report, a match found
    // only by the flush, three rejected candidates, and two matches flushed by
    // the same final byte.
    queue_run(128'({OpFirst, OpSecond}), 2);
    queue_run(128'({OpFirst, OpSecond, FolMovStore}), 3);
    queue_run({CtxSib24, CtxModrm0c, OpFirst, OpSecond, FolMovLoad, CtxGrp1, CtxModrmE2,
               OpFirst, OpSecond, FolPush, CtxCall, OpFirst, OpSecond, FolAdd, CtxZero,
               CtxOnes}, 16);
    queue_run(128'({OpFirst, OpSecond, OpFirst, OpSecond, OpFirst}), 5);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph / 2)
        0: begin
          send_idle_pct  = 16;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0: next_base = 32'hFFFF_FFFF;
        1: next_base = 32'h0000_0000;
        3: next_base = 32'hFFFF_FFF0;
        4: next_base = 32'h8000_0000;
        default: next_base = $urandom;
      endcase
      write_base(next_base);
      queued = 0;
      paused = 1'b0;
      while (queued < PhaseBytes) begin
        // Halfway through, hold the input until every result is back.
        if (!paused && queued >= PhaseBytes / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        sel = $urandom_range(19);
        if (sel < 2) len = $urandom_range(3, 1);
        else if (sel == 2) len = $urandom_range(120, 60);
        else len = $urandom_range(40, 4);
        queue_section(len);
        queued += len;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d code bytes in %0d sections under %0d base address writes",
             words_sent, sections_sent, base_writes);
    $display("checked %0d patch addresses, %0d flushes with two matches, %0d mismatches",
             patches_checked, double_hits, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
